@@ src/mmrd_pkg.sv @@
// Shared types, constants and the CRC-16/Modbus byte update for the meter
// response decoder. No dependencies; every file but mmrd_if uses this package.
package mmrd_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  FUNC_CODE  = 8'h04;
  localparam logic [7:0]  BYTE_COUNT = 8'd20;

  typedef logic [4:0] pos_t;

  localparam pos_t POS_FUNC       = 5'd1;
  localparam pos_t POS_COUNT      = 5'd2;
  localparam pos_t POS_DATA_FIRST = 5'd3;
  localparam pos_t POS_VOLT       = 5'd4;
  localparam pos_t POS_CUR_LO     = 5'd6;
  localparam pos_t POS_CUR_HI     = 5'd8;
  localparam pos_t POS_PWR_LO     = 5'd10;
  localparam pos_t POS_PWR_HI     = 5'd12;
  localparam pos_t POS_EN_LO      = 5'd14;
  localparam pos_t POS_EN_HI      = 5'd16;
  localparam pos_t POS_FREQ       = 5'd18;
  localparam pos_t POS_PF         = 5'd20;
  localparam pos_t POS_DATA_LAST  = 5'd20;
  localparam pos_t POS_CRC_LO     = 5'd23;
  localparam pos_t POS_CRC_HI     = 5'd24;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_CRC       = 3'd1;
  localparam logic [2:0] ERR_FUNC      = 3'd2;
  localparam logic [2:0] ERR_COUNT     = 3'd3;
  localparam logic [2:0] ERR_TIMEOUT   = 3'd4;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  typedef struct packed {
    logic [15:0] voltage_dv;
    logic [31:0] current_ma;
    logic [31:0] power_dw;
    logic [31:0] energy_wh;
    logic [15:0] frequency_dhz;
    logic [15:0] power_factor_centi;
    logic        frame_error;
    logic [2:0]  error_kind;
  } result_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ src/mmrd_if.sv @@
// Handshake interfaces for the decoder's input and result channels.
// Depends on nothing; payload widths follow the decoder's field list.
interface mmrd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface mmrd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] voltage_dv;
  logic [31:0] current_ma;
  logic [31:0] power_dw;
  logic [31:0] energy_wh;
  logic [15:0] frequency_dhz;
  logic [15:0] power_factor_centi;
  logic        frame_error;
  logic [2:0]  error_kind;

  modport source (
    output valid, output voltage_dv, output current_ma, output power_dw,
    output energy_wh, output frequency_dhz, output power_factor_centi,
    output frame_error, output error_kind, input ready
  );
  modport sink (
    input valid, input voltage_dv, input current_ma, input power_dw,
    input energy_wh, input frequency_dhz, input power_factor_centi,
    input frame_error, input error_kind, output ready
  );
endinterface

@@ src/mmrd_in_stage.sv @@
// Input register of the decoder: captures one item from the input channel.
// Depends on mmrd_pkg and mmrd_in_if.
module mmrd_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  mmrd_in_if.sink             in_ch,
  input  logic                advance,
  output mmrd_pkg::stage_t    stage
);

  logic               valid_r;
  logic               valid_nxt;
  mmrd_pkg::in_item_t item_r;
  logic               load;

  assign in_ch.ready = !valid_r || advance;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.mode    <= in_ch.mode;
      item_r.rx_byte <= in_ch.rx_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

@@ src/mmrd_frame_engine.sv @@
// Frame state of the decoder: byte position, running CRC, header checks,
// field assembly and the last good readings. Depends on mmrd_pkg.
module mmrd_frame_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  mmrd_pkg::in_item_t  item,
  output logic                emit,
  output mmrd_pkg::result_t   result
);

  mmrd_pkg::pos_t pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        func_ok_r, func_ok_nxt;
  logic        header_ok_r, header_ok_nxt;
  logic [7:0]  hi_hold_r, hi_hold_nxt;
  logic [15:0] lo_word_r, lo_word_nxt;

  logic [15:0] f_volt_r, f_volt_nxt;
  logic [31:0] f_cur_r, f_cur_nxt;
  logic [31:0] f_pwr_r, f_pwr_nxt;
  logic [31:0] f_en_r, f_en_nxt;
  logic [15:0] f_freq_r, f_freq_nxt;
  logic [15:0] f_pf_r, f_pf_nxt;

  logic [15:0] g_volt_r, g_volt_nxt;
  logic [31:0] g_cur_r, g_cur_nxt;
  logic [31:0] g_pwr_r, g_pwr_nxt;
  logic [31:0] g_en_r, g_en_nxt;
  logic [15:0] g_freq_r, g_freq_nxt;
  logic [15:0] g_pf_r, g_pf_nxt;

  logic [7:0]  b;
  logic [15:0] word;
  logic [15:0] rx_crc;
  logic [2:0]  kind;

  assign b      = item.rx_byte;
  assign word   = {hi_hold_r, b};
  assign rx_crc = {b, hi_hold_r};

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    func_ok_nxt   = func_ok_r;
    header_ok_nxt = header_ok_r;
    hi_hold_nxt   = hi_hold_r;
    lo_word_nxt   = lo_word_r;
    f_volt_nxt    = f_volt_r;
    f_cur_nxt     = f_cur_r;
    f_pwr_nxt     = f_pwr_r;
    f_en_nxt      = f_en_r;
    f_freq_nxt    = f_freq_r;
    f_pf_nxt      = f_pf_r;
    g_volt_nxt    = g_volt_r;
    g_cur_nxt     = g_cur_r;
    g_pwr_nxt     = g_pwr_r;
    g_en_nxt      = g_en_r;
    g_freq_nxt    = g_freq_r;
    g_pf_nxt      = g_pf_r;
    emit          = 1'b0;
    kind          = mmrd_pkg::ERR_OK;

    if (item.mode) begin
      emit          = 1'b1;
      kind          = mmrd_pkg::ERR_TIMEOUT;
      pos_nxt       = '0;
      crc_nxt       = mmrd_pkg::CRC_INIT;
      func_ok_nxt   = 1'b1;
      header_ok_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + 5'd1;
      if (pos_r < mmrd_pkg::POS_CRC_LO) begin
        crc_nxt = mmrd_pkg::crc_feed(crc_r, b);
      end
      priority if (pos_r == mmrd_pkg::POS_FUNC) begin
        if (b != mmrd_pkg::FUNC_CODE) begin
          func_ok_nxt   = 1'b0;
          header_ok_nxt = 1'b0;
        end
      end else if (pos_r == mmrd_pkg::POS_COUNT) begin
        if (b != mmrd_pkg::BYTE_COUNT) begin
          header_ok_nxt = 1'b0;
        end
      end else if (pos_r >= mmrd_pkg::POS_DATA_FIRST &&
                   pos_r <= mmrd_pkg::POS_DATA_LAST) begin
        if (pos_r[0]) begin
          hi_hold_nxt = b;
        end else begin
          unique case (pos_r)
            mmrd_pkg::POS_VOLT:   f_volt_nxt  = word;
            mmrd_pkg::POS_CUR_LO: lo_word_nxt = word;
            mmrd_pkg::POS_CUR_HI: f_cur_nxt   = {word, lo_word_r};
            mmrd_pkg::POS_PWR_LO: lo_word_nxt = word;
            mmrd_pkg::POS_PWR_HI: f_pwr_nxt   = {word, lo_word_r};
            mmrd_pkg::POS_EN_LO:  lo_word_nxt = word;
            mmrd_pkg::POS_EN_HI:  f_en_nxt    = {word, lo_word_r};
            mmrd_pkg::POS_FREQ:   f_freq_nxt  = word;
            mmrd_pkg::POS_PF:     f_pf_nxt    = word;
            default:              lo_word_nxt = lo_word_r;
          endcase
        end
      end else if (pos_r == mmrd_pkg::POS_CRC_LO) begin
        hi_hold_nxt = b;
      end else if (pos_r >= mmrd_pkg::POS_CRC_HI) begin
        emit = 1'b1;
        priority if (rx_crc != crc_r) begin
          kind = mmrd_pkg::ERR_CRC;
        end else if (!func_ok_r) begin
          kind = mmrd_pkg::ERR_FUNC;
        end else if (!header_ok_r) begin
          kind = mmrd_pkg::ERR_COUNT;
        end else begin
          kind = mmrd_pkg::ERR_OK;
        end
        if (kind == mmrd_pkg::ERR_OK) begin
          g_volt_nxt = f_volt_r;
          g_cur_nxt  = f_cur_r;
          g_pwr_nxt  = f_pwr_r;
          g_en_nxt   = f_en_r;
          g_freq_nxt = f_freq_r;
          g_pf_nxt   = f_pf_r;
        end
        pos_nxt       = '0;
        crc_nxt       = mmrd_pkg::CRC_INIT;
        func_ok_nxt   = 1'b1;
        header_ok_nxt = 1'b1;
      end else begin
        hi_hold_nxt = hi_hold_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= mmrd_pkg::CRC_INIT;
      func_ok_r   <= 1'b1;
      header_ok_r <= 1'b1;
      hi_hold_r   <= '0;
      lo_word_r   <= '0;
      f_volt_r    <= '0;
      f_cur_r     <= '0;
      f_pwr_r     <= '0;
      f_en_r      <= '0;
      f_freq_r    <= '0;
      f_pf_r      <= '0;
      g_volt_r    <= '0;
      g_cur_r     <= '0;
      g_pwr_r     <= '0;
      g_en_r      <= '0;
      g_freq_r    <= '0;
      g_pf_r      <= '0;
    end else if (take) begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      func_ok_r   <= func_ok_nxt;
      header_ok_r <= header_ok_nxt;
      hi_hold_r   <= hi_hold_nxt;
      lo_word_r   <= lo_word_nxt;
      f_volt_r    <= f_volt_nxt;
      f_cur_r     <= f_cur_nxt;
      f_pwr_r     <= f_pwr_nxt;
      f_en_r      <= f_en_nxt;
      f_freq_r    <= f_freq_nxt;
      f_pf_r      <= f_pf_nxt;
      g_volt_r    <= g_volt_nxt;
      g_cur_r     <= g_cur_nxt;
      g_pwr_r     <= g_pwr_nxt;
      g_en_r      <= g_en_nxt;
      g_freq_r    <= g_freq_nxt;
      g_pf_r      <= g_pf_nxt;
    end
  end

  assign result.voltage_dv         = g_volt_nxt;
  assign result.current_ma         = g_cur_nxt;
  assign result.power_dw           = g_pwr_nxt;
  assign result.energy_wh          = g_en_nxt;
  assign result.frequency_dhz      = g_freq_nxt;
  assign result.power_factor_centi = g_pf_nxt;
  assign result.frame_error        = (kind != mmrd_pkg::ERR_OK);
  assign result.error_kind         = kind;

endmodule

@@ src/modbus_meter_response_decoder_core.sv @@
// Top level of the meter response decoder: input register, frame engine and
// result register. Depends on mmrd_pkg, mmrd_if, mmrd_in_stage, mmrd_frame_engine.
//
// The input channel carries one item per reply byte (mode 0) or a timeout
// event (mode 1). A reply is 25 bytes; the 25th byte produces one result
// item that carries the last good readings and the frame status. A timeout
// produces one result item with error kind timeout and restarts the frame.
// All other bytes produce no result.
// An accepted item waits in the input register until the result register can
// move, is then processed by the frame engine in a single pass, and its
// result, if any, is written into the result register. One item can be
// accepted every cycle while the receiver does not stall; the rate is set by
// the single-pass engine.
// Synchronous active-low reset empties both registers, restarts the frame
// and clears the last good readings to zero.
// When the receiver stalls, the result register holds its item; the input
// register still takes one more item, and input ready drops only when the
// input register is full and the result register cannot move.
module modbus_meter_response_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  mmrd_in_if.sink     in_ch,
  mmrd_out_if.source  out_ch
);

  mmrd_pkg::stage_t  stage;
  mmrd_pkg::result_t result;
  mmrd_pkg::result_t out_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              advance;
  logic              take;
  logic              emit;

  assign advance = !out_valid_r || out_ch.ready;
  assign take    = stage.valid && advance;

  mmrd_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  mmrd_frame_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (stage.item),
    .emit   (emit),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_r <= result;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.voltage_dv         = out_r.voltage_dv;
  assign out_ch.current_ma         = out_r.current_ma;
  assign out_ch.power_dw           = out_r.power_dw;
  assign out_ch.energy_wh          = out_r.energy_wh;
  assign out_ch.frequency_dhz      = out_r.frequency_dhz;
  assign out_ch.power_factor_centi = out_r.power_factor_centi;
  assign out_ch.frame_error        = out_r.frame_error;
  assign out_ch.error_kind         = out_r.error_kind;

  a_timeout_result: assert property (@(posedge clk) disable iff (!rst_n)
    take && stage.item.mode |=>
      out_ch.valid && out_ch.error_kind == mmrd_pkg::ERR_TIMEOUT)
    else $error("timeout item did not produce a timeout result");

  a_status_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.frame_error == (out_ch.error_kind != mmrd_pkg::ERR_OK)))
    else $error("frame_error disagrees with error_kind");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(take && emit))
    else $error("result appeared without an emitting item");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> stage.valid && !advance)
    else $error("input stalled while the pipeline could move");

endmodule

@@ tb/sv/modbus_meter_response_decoder_core_tb.sv @@
// Testbench for the meter response decoder: sends reply frames byte by byte,
// predicts each status item and checks it. Depends on mmrd_pkg, mmrd_if and
// the decoder RTL.
module modbus_meter_response_decoder_core_tb;

  localparam int CLK_HALF = 6;
  localparam int RUN_LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 800;
  localparam int FRAME_BYTES = 25;
  localparam int CRC_COVERED = 23;
  localparam int DRAIN_CYCLES = 8;
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;

  typedef logic [15:0] reg_words_t [9];

  logic clk;
  logic rst_n;

  mmrd_in_if in_ch ();
  mmrd_out_if out_ch ();

  modbus_meter_response_decoder_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mmrd_pkg::pos_t frame_pos;
  logic [15:0]    frame_crc;
  logic           header_good;
  logic           func_good;
  logic [7:0]     hold_hi_byte;
  logic [15:0]    hold_lo_word;
  logic [31:0]    frame_vals [6];
  logic [31:0]    last_good [6];

  mmrd_pkg::result_t pending_reports [$];
  int                error_count;
  int                items_sent;
  bit                no_idle;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      fb = acc[0] ^ data[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ mmrd_pkg::CRC_POLY;
    end
    return acc;
  endfunction

  function automatic void restart_frame();
    frame_pos = '0;
    frame_crc = mmrd_pkg::CRC_INIT;
    header_good = 1'b1;
    func_good = 1'b1;
  endfunction

  function automatic void push_report(input logic [2:0] kind);
    mmrd_pkg::result_t rep;
    rep.voltage_dv = last_good[0][15:0];
    rep.current_ma = last_good[1];
    rep.power_dw = last_good[2];
    rep.energy_wh = last_good[3];
    rep.frequency_dhz = last_good[4][15:0];
    rep.power_factor_centi = last_good[5][15:0];
    rep.frame_error = (kind != mmrd_pkg::ERR_OK);
    rep.error_kind = kind;
    pending_reports.push_back(rep);
  endfunction

  function automatic void decode_byte(input logic m, input logic [7:0] b);
    logic [15:0] word;
    logic [15:0] rx_crc;
    logic [2:0]  kind;
    if (m == MODE_TIMEOUT) begin
      restart_frame();
      push_report(mmrd_pkg::ERR_TIMEOUT);
      return;
    end
    if (frame_pos < mmrd_pkg::POS_CRC_LO) frame_crc = modbus_crc_step(frame_crc, b);
    if (frame_pos == mmrd_pkg::POS_FUNC) begin
      if (b != mmrd_pkg::FUNC_CODE) begin
        func_good = 1'b0;
        header_good = 1'b0;
      end
    end else if (frame_pos == mmrd_pkg::POS_COUNT) begin
      if (b != mmrd_pkg::BYTE_COUNT) header_good = 1'b0;
    end else if (frame_pos >= mmrd_pkg::POS_DATA_FIRST &&
                 frame_pos <= mmrd_pkg::POS_DATA_LAST) begin
      if (frame_pos[0]) begin
        hold_hi_byte = b;
      end else begin
        word = {hold_hi_byte, b};
        unique case (frame_pos)
          mmrd_pkg::POS_VOLT: frame_vals[0] = {16'h0000, word};
          mmrd_pkg::POS_CUR_LO, mmrd_pkg::POS_PWR_LO, mmrd_pkg::POS_EN_LO:
            hold_lo_word = word;
          mmrd_pkg::POS_CUR_HI: frame_vals[1] = {word, hold_lo_word};
          mmrd_pkg::POS_PWR_HI: frame_vals[2] = {word, hold_lo_word};
          mmrd_pkg::POS_EN_HI: frame_vals[3] = {word, hold_lo_word};
          mmrd_pkg::POS_FREQ: frame_vals[4] = {16'h0000, word};
          mmrd_pkg::POS_PF: frame_vals[5] = {16'h0000, word};
          default: ;
        endcase
      end
    end else if (frame_pos == mmrd_pkg::POS_CRC_LO) begin
      hold_hi_byte = b;
    end else if (frame_pos == mmrd_pkg::POS_CRC_HI) begin
      rx_crc = {b, hold_hi_byte};
      if (rx_crc != frame_crc) kind = mmrd_pkg::ERR_CRC;
      else if (!func_good) kind = mmrd_pkg::ERR_FUNC;
      else if (!header_good) kind = mmrd_pkg::ERR_COUNT;
      else kind = mmrd_pkg::ERR_OK;
      if (kind == mmrd_pkg::ERR_OK) last_good = frame_vals;
      restart_frame();
      push_report(kind);
      return;
    end
    frame_pos = frame_pos + 1'b1;
  endfunction

  task automatic send_item(input logic m, input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(m, b);
    items_sent++;
  endtask

  // Builds a reply with a correct CRC, optionally corrupted, and sends the
  // first n_bytes of it; a short frame is closed by a timeout.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                            input logic [7:0] count, input reg_words_t w,
                            input logic [15:0] crc_flip, input int n_bytes);
    logic [7:0]  frame [FRAME_BYTES];
    logic [15:0] crc;
    frame[0] = addr;
    frame[1] = func;
    frame[2] = count;
    for (int k = 0; k < 9; k++) begin
      frame[3 + 2 * k] = w[k][15:8];
      frame[4 + 2 * k] = w[k][7:0];
    end
    frame[21] = 8'($urandom);
    frame[22] = 8'($urandom);
    crc = mmrd_pkg::CRC_INIT;
    for (int k = 0; k < CRC_COVERED; k++) crc = modbus_crc_step(crc, frame[k]);
    crc = crc ^ crc_flip;
    frame[23] = crc[7:0];
    frame[24] = crc[15:8];
    for (int k = 0; k < n_bytes; k++) send_item(MODE_BYTE, frame[k]);
    if (n_bytes < FRAME_BYTES) send_item(MODE_TIMEOUT, 8'($urandom));
  endtask

  function automatic reg_words_t random_words();
    reg_words_t w;
    for (int k = 0; k < 9; k++) begin
      case ($urandom_range(0, 7))
        0: w[k] = 16'h0000;
        1: w[k] = 16'hFFFF;
        default: w[k] = 16'($urandom);
      endcase
    end
    return w;
  endfunction

  function automatic reg_words_t fill_words(input logic [15:0] value);
    reg_words_t w;
    for (int k = 0; k < 9; k++) w[k] = value;
    return w;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0h actual %0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_report(input mmrd_pkg::result_t got);
    mmrd_pkg::result_t want;
    if (pending_reports.size() == 0) begin
      $error("result item arrived with no expected result");
      error_count++;
    end else begin
      want = pending_reports.pop_front();
      compare_field("voltage_dv", want.voltage_dv, got.voltage_dv);
      compare_field("current_ma", want.current_ma, got.current_ma);
      compare_field("power_dw", want.power_dw, got.power_dw);
      compare_field("energy_wh", want.energy_wh, got.energy_wh);
      compare_field("frequency_dhz", want.frequency_dhz, got.frequency_dhz);
      compare_field("power_factor_centi", want.power_factor_centi,
                    got.power_factor_centi);
      compare_field("frame_error", want.frame_error, got.frame_error);
      compare_field("error_kind", want.error_kind, got.error_kind);
    end
  endtask

  task automatic test_timeout_when_idle();
    send_item(MODE_TIMEOUT, 8'hFF);
  endtask

  task automatic test_extreme_good_frames();
    send_frame(8'hFF, mmrd_pkg::FUNC_CODE, mmrd_pkg::BYTE_COUNT, fill_words(16'hFFFF),
               16'h0000, FRAME_BYTES);
    send_frame(8'h00, mmrd_pkg::FUNC_CODE, mmrd_pkg::BYTE_COUNT, fill_words(16'h0000),
               16'h0000, FRAME_BYTES);
  endtask

  task automatic test_header_faults();
    // Both header bytes wrong with a valid CRC: the function code wins.
    send_frame(8'h5A, 8'h03, 8'h14 ^ 8'hFF, random_words(), 16'h0000, FRAME_BYTES);
    // A wrong CRC outranks a wrong function code.
    send_frame(8'hA5, 8'h83, mmrd_pkg::BYTE_COUNT, random_words(), 16'h8001, FRAME_BYTES);
  endtask

  task automatic test_partial_frame_abort();
    send_frame(8'h11, mmrd_pkg::FUNC_CODE, mmrd_pkg::BYTE_COUNT, random_words(),
               16'h0000, FRAME_BYTES - 1);
    send_frame(8'h22, mmrd_pkg::FUNC_CODE, mmrd_pkg::BYTE_COUNT, random_words(),
               16'h0000, FRAME_BYTES);
  endtask

  task automatic test_random_traffic();
    int         pick;
    logic [7:0] func;
    logic [7:0] count;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      func = $urandom_range(0, 1) ? 8'($urandom) : mmrd_pkg::FUNC_CODE;
      count = $urandom_range(0, 1) ? 8'($urandom) : mmrd_pkg::BYTE_COUNT;
      if (pick < 55) begin
        send_frame(8'($urandom), mmrd_pkg::FUNC_CODE, mmrd_pkg::BYTE_COUNT,
                   random_words(), 16'h0000, FRAME_BYTES);
      end else if (pick < 65) begin
        send_frame(8'($urandom), func, count, random_words(), 16'h0000, FRAME_BYTES);
      end else if (pick < 75) begin
        send_frame(8'($urandom), func, count, random_words(),
                   16'($urandom_range(1, 16'hFFFF)), FRAME_BYTES);
      end else if (pick < 88) begin
        send_frame(8'($urandom), func, count, random_words(), 16'h0000,
                   $urandom_range(0, FRAME_BYTES - 1));
      end else begin
        repeat ($urandom_range(1, 40))
          send_item($urandom_range(0, 7) == 0, 8'($urandom));
        send_item(MODE_TIMEOUT, 8'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_BYTE;
    in_ch.rx_byte = 8'h00;
    error_count = 0;
    items_sent = 0;
    no_idle = 1'b0;
    restart_frame();
    hold_hi_byte = '0;
    hold_lo_word = '0;
    for (int i = 0; i < 6; i++) begin
      frame_vals[i] = '0;
      last_good[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_timeout_when_idle();
    test_extreme_good_frames();
    test_header_faults();
    test_partial_frame_abort();
    test_random_traffic();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS modbus_meter_response_decoder_core");
    end else begin
      $display("FAIL modbus_meter_response_decoder_core");
    end
    $finish;
  end

  initial begin
    int                stall;
    mmrd_pkg::result_t got;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.voltage_dv = out_ch.voltage_dv;
      got.current_ma = out_ch.current_ma;
      got.power_dw = out_ch.power_dw;
      got.energy_wh = out_ch.energy_wh;
      got.frequency_dhz = out_ch.frequency_dhz;
      got.power_factor_centi = out_ch.power_factor_centi;
      got.frame_error = out_ch.frame_error;
      got.error_kind = out_ch.error_kind;
      check_report(got);
    end
  end

  initial begin
    #(2 * CLK_HALF * RUN_LIMIT_CYCLES);
    $display("FAIL modbus_meter_response_decoder_core");
    $finish;
  end

endmodule

@@ files.f @@
src/mmrd_pkg.sv
src/mmrd_if.sv
src/mmrd_in_stage.sv
src/mmrd_frame_engine.sv
src/modbus_meter_response_decoder_core.sv
tb/sv/modbus_meter_response_decoder_core_tb.sv
